[design/bpa_pkg.sv]
// Shared types and codes for the buddy page allocator.
// Used by bpa_ctrl, bpa_dpath and the top level; depends on nothing.
package bpa_pkg;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SEARCH, S_PULL, S_SPLIT, S_PUSH_A, S_PUSH_B,
    S_FINAL, S_FRD, S_FCHK, S_MRD, S_MCHK, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SEARCH, OP_PICK, OP_PULL, OP_SPLIT,
    OP_PUSH_A, OP_PUSH_B, OP_FINAL, OP_FRD, OP_MRD, OP_MERGE,
    OP_RES_BAD, OP_RES_NOBLK, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic ord_bad;
    logic is_free;
    logic k_ge_max;
    logic head_valid;
    logic k_gt_ord;
    logic free_bad;
    logic merge_last;
    logic buddy_ok;
    logic clr_last;
  } dp_stat_t;

  typedef struct packed {
    logic       flag;
    logic [3:0] order;
  } meta_t;

endpackage

[design/bpa_ctrl.sv]
// Sequencer for the buddy page allocator: walks search, split and merge steps.
// Depends on bpa_pkg; drives the op code into bpa_dpath.
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bpa_pkg::dp_stat_t stat,
  output bpa_pkg::dp_op_t   op
);

  bpa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op            = bpa_pkg::OP_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        op = bpa_pkg::OP_CLEAR;
        if (stat.clr_last) state_nxt = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          op        = bpa_pkg::OP_LOAD;
          state_nxt = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        if (stat.ord_bad) begin
          op        = bpa_pkg::OP_RES_BAD;
          state_nxt = bpa_pkg::S_EMIT;
        end else if (stat.is_free) begin
          state_nxt = bpa_pkg::S_FRD;
        end else begin
          state_nxt = bpa_pkg::S_SEARCH;
        end
      end
      bpa_pkg::S_SEARCH: begin
        if (stat.k_ge_max) begin
          op        = bpa_pkg::OP_RES_NOBLK;
          state_nxt = bpa_pkg::S_EMIT;
        end else if (stat.head_valid) begin
          op        = bpa_pkg::OP_PICK;
          state_nxt = bpa_pkg::S_PULL;
        end else begin
          op = bpa_pkg::OP_SEARCH;
        end
      end
      bpa_pkg::S_PULL: begin
        op        = bpa_pkg::OP_PULL;
        state_nxt = bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_SPLIT: begin
        if (stat.k_gt_ord) begin
          op        = bpa_pkg::OP_SPLIT;
          state_nxt = bpa_pkg::S_PUSH_A;
        end else begin
          state_nxt = bpa_pkg::S_FINAL;
        end
      end
      bpa_pkg::S_FINAL: begin
        op        = bpa_pkg::OP_FINAL;
        state_nxt = bpa_pkg::S_EMIT;
      end
      bpa_pkg::S_PUSH_A: begin
        op        = bpa_pkg::OP_PUSH_A;
        state_nxt = bpa_pkg::S_PUSH_B;
      end
      bpa_pkg::S_PUSH_B: begin
        op        = bpa_pkg::OP_PUSH_B;
        state_nxt = stat.is_free ? bpa_pkg::S_EMIT : bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_FRD: begin
        op        = bpa_pkg::OP_FRD;
        state_nxt = bpa_pkg::S_FCHK;
      end
      bpa_pkg::S_FCHK: begin
        if (stat.free_bad) begin
          op        = bpa_pkg::OP_RES_BAD;
          state_nxt = bpa_pkg::S_EMIT;
        end else begin
          state_nxt = bpa_pkg::S_MRD;
        end
      end
      bpa_pkg::S_MRD: begin
        if (stat.merge_last) begin
          state_nxt = bpa_pkg::S_PUSH_A;
        end else begin
          op        = bpa_pkg::OP_MRD;
          state_nxt = bpa_pkg::S_MCHK;
        end
      end
      bpa_pkg::S_MCHK: begin
        if (stat.buddy_ok) begin
          op        = bpa_pkg::OP_MERGE;
          state_nxt = bpa_pkg::S_MRD;
        end else begin
          state_nxt = bpa_pkg::S_PUSH_A;
        end
      end
      bpa_pkg::S_EMIT: begin
        // hold until the output register is free or being taken
        if (!(out_valid_r && out_stall)) begin
          op            = bpa_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = bpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != bpa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/bpa_dpath.sv]
// Datapath for the buddy page allocator: page memories, list heads, counters.
// Depends on bpa_pkg; executes one op code from bpa_ctrl per cycle.
module bpa_dpath #(
  parameter int NUM_PAGES = 4096,
  parameter int MAX_ORDER = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bpa_pkg::dp_op_t   op,
  input  logic              in_kind,
  input  logic [3:0]        in_order,
  input  logic [11:0]       in_page,
  output bpa_pkg::dp_stat_t stat,
  output logic [11:0]       out_page_out,
  output logic [1:0]        out_status,
  output logic [12:0]       out_free_total,
  output logic [12:0]       out_order_free_count
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int LW = $clog2(NUM_PAGES + 1);
  localparam int CW = LW;
  localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int OW = $clog2(MAX_ORDER + 1);
  localparam logic [31:0]   NP32 = 32'(NUM_PAGES);
  localparam logic [31:0]   MO32 = 32'(MAX_ORDER);
  localparam logic [LW-1:0] NIL  = LW'(NUM_PAGES);

  bpa_pkg::meta_t meta_mem [NUM_PAGES];
  logic [LW-1:0]  next_mem [NUM_PAGES];
  logic [LW-1:0]  prev_mem [NUM_PAGES];

  logic           kind_r;
  logic [3:0]     ord_r;
  logic [11:0]    page_r;
  logic [OW-1:0]  k_r;
  logic [LW-1:0]  p_r, t_r;
  logic           t_oob_r;
  logic [AW-1:0]  clr_r;
  logic [LW-1:0]  head_r [MAX_ORDER];
  logic [CW-1:0]  cnt_r  [MAX_ORDER];
  logic [CW-1:0]  total_r;
  logic [11:0]    res_page_r;
  logic [1:0]     res_status_r;
  bpa_pkg::meta_t rd_meta_r;
  logic [LW-1:0]  rd_next_r, rd_prev_r;
  logic [11:0]    out_page_r;
  logic [1:0]     out_status_r;
  logic [12:0]    out_total_r, out_count_r;

  logic [KW-1:0]  kidx, oidx;
  logic [31:0]    k_sz32, ord_sz32, b32, page32;
  logic [CW-1:0]  sz_c;
  logic [LW-1:0]  head_k, n_norm, v_norm;
  logic           h_valid, n_valid, v_valid;
  logic [AW-1:0]  rd_addr;

  logic           meta_we, next_we, prev_we;
  logic [AW-1:0]  meta_wa, next_wa, prev_wa;
  bpa_pkg::meta_t meta_wd;
  logic [LW-1:0]  next_wd, prev_wd;

  assign kidx     = k_r[KW-1:0];
  assign oidx     = KW'(ord_r);
  assign k_sz32   = 32'(1) << k_r;
  assign ord_sz32 = 32'(1) << ord_r;
  assign page32   = 32'(page_r);
  assign b32      = 32'(p_r) ^ k_sz32;
  assign sz_c     = CW'(k_sz32);
  assign head_k   = head_r[kidx];
  assign h_valid  = 32'(head_k) < NP32;
  assign n_valid  = 32'(rd_next_r) < NP32;
  assign v_valid  = 32'(rd_prev_r) < NP32;
  assign n_norm   = n_valid ? rd_next_r : NIL;
  assign v_norm   = v_valid ? rd_prev_r : NIL;

  always_comb begin
    stat.ord_bad    = 32'(ord_r) >= MO32;
    stat.is_free    = (kind_r == bpa_pkg::KIND_FREE);
    stat.k_ge_max   = 32'(k_r) >= MO32;
    stat.head_valid = h_valid;
    stat.k_gt_ord   = 32'(k_r) > 32'(ord_r);
    stat.free_bad   = (page32 >= NP32) || ((page32 & (ord_sz32 - 32'd1)) != 32'd0) ||
                      (page32 + ord_sz32 > NP32) || rd_meta_r.flag ||
                      (32'(total_r) + ord_sz32 > NP32);
    stat.merge_last = 32'(k_r) + 32'd1 >= MO32;
    stat.buddy_ok   = !t_oob_r && rd_meta_r.flag && (rd_meta_r.order == 4'(k_r));
    stat.clr_last   = (clr_r == AW'(NUM_PAGES - 1));
  end

  always_comb begin
    unique case (op)
      bpa_pkg::OP_PICK: rd_addr = AW'(head_k);
      bpa_pkg::OP_FRD:  rd_addr = AW'(page_r);
      bpa_pkg::OP_MRD:  rd_addr = AW'(b32);
      default:          rd_addr = AW'(t_r);
    endcase
  end

  always_comb begin
    meta_we = 1'b0; meta_wa = AW'(p_r); meta_wd = '0;
    next_we = 1'b0; next_wa = AW'(p_r); next_wd = head_k;
    prev_we = 1'b0; prev_wa = AW'(p_r); prev_wd = NIL;
    unique case (op)
      bpa_pkg::OP_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_r;
      end
      bpa_pkg::OP_PULL, bpa_pkg::OP_MERGE: begin
        // unlink the block at t_r: patch neighbours, drop its free mark
        meta_we       = 1'b1;
        meta_wa       = AW'(t_r);
        meta_wd.order = rd_meta_r.order;
        next_we       = v_valid;
        next_wa       = AW'(rd_prev_r);
        next_wd       = n_norm;
        prev_we       = n_valid;
        prev_wa       = AW'(rd_next_r);
        prev_wd       = v_norm;
      end
      bpa_pkg::OP_PUSH_A: begin
        meta_we = 1'b1;
        meta_wd = '{flag: 1'b1, order: 4'(k_r)};
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      bpa_pkg::OP_PUSH_B: begin
        prev_we = h_valid;
        prev_wa = AW'(head_k);
        prev_wd = p_r;
      end
      bpa_pkg::OP_FINAL: begin
        meta_we = 32'(p_r) < NP32;
        meta_wd = '{flag: 1'b0, order: ord_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    rd_meta_r <= meta_mem[rd_addr];
    rd_next_r <= next_mem[rd_addr];
    rd_prev_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (op)
      bpa_pkg::OP_LOAD: begin
        kind_r <= in_kind;
        ord_r  <= in_order;
        page_r <= in_page;
        k_r    <= OW'(in_order);
        p_r    <= LW'(in_page);
      end
      bpa_pkg::OP_SEARCH: k_r <= k_r + OW'(1);
      bpa_pkg::OP_PICK: begin
        t_r <= head_k;
        p_r <= head_k;
      end
      bpa_pkg::OP_SPLIT: k_r <= k_r - OW'(1);
      bpa_pkg::OP_PUSH_B: begin
        if (kind_r == bpa_pkg::KIND_ALLOC) begin
          p_r <= p_r + LW'(k_sz32);
        end else begin
          res_page_r   <= page_r;
          res_status_r <= bpa_pkg::ST_OK;
        end
      end
      bpa_pkg::OP_MRD: begin
        t_r     <= LW'(b32);
        t_oob_r <= b32 >= NP32;
      end
      bpa_pkg::OP_MERGE: begin
        if (t_r < p_r) p_r <= t_r;
        k_r <= k_r + OW'(1);
      end
      bpa_pkg::OP_FINAL: begin
        res_page_r   <= 12'(p_r);
        res_status_r <= bpa_pkg::ST_OK;
      end
      bpa_pkg::OP_RES_BAD: begin
        res_page_r   <= (kind_r == bpa_pkg::KIND_FREE) ? page_r : 12'd0;
        res_status_r <= bpa_pkg::ST_BAD;
      end
      bpa_pkg::OP_RES_NOBLK: begin
        res_page_r   <= 12'd0;
        res_status_r <= bpa_pkg::ST_NOBLK;
      end
      bpa_pkg::OP_EMIT: begin
        out_page_r   <= res_page_r;
        out_status_r <= res_status_r;
        out_total_r  <= 13'(total_r);
        out_count_r  <= stat.ord_bad ? 13'd0 : 13'(cnt_r[oidx]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      total_r <= '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        head_r[i] <= NIL;
        cnt_r[i]  <= '0;
      end
    end else begin
      case (op)
        bpa_pkg::OP_CLEAR: clr_r <= clr_r + AW'(1);
        bpa_pkg::OP_PULL, bpa_pkg::OP_MERGE: begin
          if (!v_valid) head_r[kidx] <= n_norm;
          if (cnt_r[kidx] != '0) cnt_r[kidx] <= cnt_r[kidx] - CW'(1);
          total_r <= (total_r >= sz_c) ? total_r - sz_c : '0;
        end
        bpa_pkg::OP_PUSH_B: begin
          head_r[kidx] <= p_r;
          cnt_r[kidx]  <= cnt_r[kidx] + CW'(1);
          total_r      <= total_r + sz_c;
        end
        default: ;
      endcase
    end
  end

  assign out_page_out         = out_page_r;
  assign out_status           = out_status_r;
  assign out_free_total       = out_total_r;
  assign out_order_free_count = out_count_r;

endmodule

[design/buddy_page_allocator_core.sv]
// Buddy page allocator, top level: joins bpa_ctrl and bpa_dpath.
// Depends on bpa_pkg, bpa_ctrl and bpa_dpath.
//
// Usage: one request on the in_ channel (kind, order, page) yields exactly
// one result on the out_ channel (page_out, status, free_total and the free
// block count of the requested order). Both channels use valid/stall.
// Requests are handled one at a time. An allocate skips empty orders, takes
// the head block of the first non-empty order and splits it down to the
// requested order; a free is checked, then merges with its buddy until the
// top order is reached or the buddy is not a free block of the same order.
// Each step is one read-modify-write of the page memories, which have a
// single write port each. After reset a clearing pass zeroes the page marks;
// in_stall stays high meanwhile. All pages start allocated, with empty lists.
// A finished result sits in the output register; the next request is
// accepted while it waits, and a stalled result holds its payload until
// taken. The block then waits before writing its next result.
module buddy_page_allocator_core #(
  parameter int NUM_PAGES = 4096,
  parameter int MAX_ORDER = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_order,
  input  logic [11:0] in_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_page_out,
  output logic [1:0]  out_status,
  output logic [12:0] out_free_total,
  output logic [12:0] out_order_free_count
);

  bpa_pkg::dp_op_t   op;
  bpa_pkg::dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .op        (op)
  );

  bpa_dpath #(
    .NUM_PAGES (NUM_PAGES),
    .MAX_ORDER (MAX_ORDER)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op                   (op),
    .in_kind              (in_kind),
    .in_order             (in_order),
    .in_page              (in_page),
    .stat                 (stat),
    .out_page_out         (out_page_out),
    .out_status           (out_status),
    .out_free_total       (out_free_total),
    .out_order_free_count (out_order_free_count)
  );

endmodule

[design/bpa_checker.sv]
// Port-level checks for buddy_page_allocator_core, bound to the top level.
// Depends on bpa_pkg for the status codes.
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_page_out,
  input logic [1:0]  out_status
);

  // one request at a time: taking a request closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_page_out))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == bpa_pkg::ST_OK || out_status == bpa_pkg::ST_NOBLK ||
                  out_status == bpa_pkg::ST_BAD)
    else $error("undefined status code");

  a_noblk_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bpa_pkg::ST_NOBLK |-> out_page_out == 12'd0)
    else $error("failed allocate returned a page");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);

[sim/bpa_checker.sv]
// Checker for the buddy page allocator: watches both channels, keeps its own
// copy of the free lists and compares every result. Depends on bpa_pkg only.
module bpa_scoreboard #(
  parameter int NUM_PAGES = 4096,
  parameter int MAX_ORDER = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [3:0]  in_order,
  input  logic [11:0] in_page,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_page_out,
  input  logic [1:0]  out_status,
  input  logic [12:0] out_free_total,
  input  logic [12:0] out_order_free_count,
  output int          fail_count,
  output int          pending,
  output int          n_alloc_ok,
  output int          n_free_ok,
  output int          n_noblk,
  output int          n_bad
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] page_out;
    logic [1:0]  status;
    logic [12:0] free_total;
    logic [12:0] order_free_count;
  } alloc_result_t;

  localparam int NIL = NUM_PAGES;

  bit          is_head[NUM_PAGES];
  logic [3:0]  blk_ord[NUM_PAGES];
  int          nxt[NUM_PAGES];
  int          prv[NUM_PAGES];
  int          head[MAX_ORDER];
  int          cnt[MAX_ORDER];
  int          pool_free;
  alloc_result_t expected_results[$];

  function automatic void list_push(int p, int k);
    int h;
    h = head[k];
    is_head[p] = 1;
    blk_ord[p] = k[3:0];
    nxt[p] = (h < NUM_PAGES) ? h : NIL;
    prv[p] = NIL;
    if (h < NUM_PAGES) prv[h] = p;
    head[k] = p;
    cnt[k]++;
    pool_free += 1 << k;
  endfunction

  function automatic void list_pull(int p, int k);
    int n, v, sz;
    n = nxt[p];
    v = prv[p];
    sz = 1 << k;
    if (v < NUM_PAGES) nxt[v] = (n < NUM_PAGES) ? n : NIL;
    else head[k] = (n < NUM_PAGES) ? n : NIL;
    if (n < NUM_PAGES) prv[n] = (v < NUM_PAGES) ? v : NIL;
    is_head[p] = 0;
    if (cnt[k] > 0) cnt[k]--;
    pool_free = (pool_free >= sz) ? pool_free - sz : 0;
  endfunction

  function automatic alloc_result_t serve_request(logic kind, int ord, int page);
    alloc_result_t r;
    int c, p, k, b, sz;
    r = '0;
    if (ord >= MAX_ORDER) begin
      r.status = bpa_pkg::ST_BAD;
      r.page_out = (kind == bpa_pkg::KIND_FREE) ? page[11:0] : '0;
    end else if (kind == bpa_pkg::KIND_ALLOC) begin
      c = ord;
      while (c < MAX_ORDER && head[c] >= NUM_PAGES) c++;
      if (c >= MAX_ORDER) begin
        r.status = bpa_pkg::ST_NOBLK;
      end else begin
        p = head[c];
        list_pull(p, c);
        while (c > ord) begin
          c--;
          list_push(p, c);
          p += 1 << c;
        end
        if (p < NUM_PAGES) begin
          is_head[p] = 0;
          blk_ord[p] = ord[3:0];
        end
        r.status = bpa_pkg::ST_OK;
        r.page_out = p[11:0];
      end
    end else begin
      sz = 1 << ord;
      r.page_out = page[11:0];
      if (page >= NUM_PAGES || (page & (sz - 1)) != 0 || page + sz > NUM_PAGES ||
          is_head[page] || pool_free + sz > NUM_PAGES) begin
        r.status = bpa_pkg::ST_BAD;
      end else begin
        p = page;
        k = ord;
        while (k + 1 < MAX_ORDER) begin
          b = p ^ (1 << k);
          if (b >= NUM_PAGES || !is_head[b] || blk_ord[b] != k) break;
          list_pull(b, k);
          if (b < p) p = b;
          k++;
        end
        list_push(p, k);
        r.status = bpa_pkg::ST_OK;
      end
    end
    r.free_total = pool_free[12:0];
    r.order_free_count = (ord < MAX_ORDER) ? cnt[ord][12:0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t e, a;
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        is_head[i] = 0; blk_ord[i] = 0; nxt[i] = NIL; prv[i] = NIL;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
        head[i] = NIL; cnt[i] = 0;
      end
      pool_free = 0;
      expected_results.delete();
      fail_count <= 0;
      n_alloc_ok <= 0; n_free_ok <= 0; n_noblk <= 0; n_bad <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        e = serve_request(in_kind, int'(in_order), int'(in_page));
        expected_results.push_back(e);
        if (e.status == bpa_pkg::ST_BAD) n_bad <= n_bad + 1;
        else if (e.status == bpa_pkg::ST_NOBLK) n_noblk <= n_noblk + 1;
        else if (in_kind == bpa_pkg::KIND_FREE) n_free_ok <= n_free_ok + 1;
        else n_alloc_ok <= n_alloc_ok + 1;
      end
      if (out_valid && !out_stall) begin
        a.page_out = out_page_out;
        a.status = out_status;
        a.free_total = out_free_total;
        a.order_free_count = out_order_free_count;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, a);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (a !== e) begin
            $display("%0t: mismatch page %0d/%0d status %0d/%0d total %0d/%0d count %0d/%0d",
                     $time, e.page_out, a.page_out, e.status, a.status,
                     e.free_total, a.free_total, e.order_free_count, a.order_free_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule

[sim/tb_top.sv]
// Top of the buddy page allocator testbench: clock, reset, request stimulus
// and verdict. Depends on bpa_pkg, bpa_scoreboard and the allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = bpa_pkg::KIND_ALLOC;
  logic [3:0]  in_order = '0;
  logic [11:0] in_page = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_page_out;
  logic [1:0]  out_status;
  logic [12:0] out_free_total;
  logic [12:0] out_order_free_count;
  int fail_count, pending, n_alloc_ok, n_free_ok, n_noblk, n_bad;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  logic [11:0] owned_page[$];
  logic [3:0]  owned_ord[$];
  logic [3:0]  u_chk_alloc_q[$];

  buddy_page_allocator_core u_top (.*);
  bpa_scoreboard u_chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_stall);
  end

  // offer one request and hold it until taken, then idle at the set rate
  task automatic send_request(logic kind, logic [3:0] ord, logic [11:0] page);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_order <= ord;
    in_page <= page;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // drop valid; the block cannot take another request yet
    in_valid <= 1'b0;
    @(posedge clk);
    while ($urandom_range(99) < send_idle) @(posedge clk);
  endtask

  // capture allocated blocks so that frees mostly target real blocks
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall && in_kind == bpa_pkg::KIND_ALLOC)
      u_chk_alloc_q.push_back(in_order);
    else if (rst_n && in_valid && !in_stall)
      u_chk_alloc_q.push_back(4'hf);
    if (rst_n && out_valid && !out_stall && u_chk_alloc_q.size() > 0) begin
      if (u_chk_alloc_q[0] != 4'hf && out_status == bpa_pkg::ST_OK) begin
        owned_page.push_back(out_page_out);
        owned_ord.push_back(u_chk_alloc_q[0]);
      end
      void'(u_chk_alloc_q.pop_front());
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_request();
    int r, i;
    logic [3:0] o;
    r = $urandom_range(99);
    if (r < 45) begin
      o = ($urandom_range(9) == 0) ? 4'($urandom_range(10)) : 4'($urandom_range(3));
      send_request(bpa_pkg::KIND_ALLOC, o, 12'($urandom));
    end else if (r < 90 && owned_page.size() > 0) begin
      i = $urandom_range(owned_page.size() - 1);
      send_request(bpa_pkg::KIND_FREE, owned_ord[i], owned_page[i]);
      owned_page.delete(i);
      owned_ord.delete(i);
    end else begin
      // noise: bad orders, misaligned or double frees
      send_request(1'($urandom_range(1)), 4'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    int phase;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty pool, bad orders, populate, split, merge, bad frees
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, 12'hfff);
    send_request(bpa_pkg::KIND_ALLOC, 4'd15, 12'h000);
    send_request(bpa_pkg::KIND_FREE, 4'd11, 12'h800);
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'h000);
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'h000);
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'h401);
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'hc00);
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'h400);
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'h800);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 12'hfff);
    send_request(bpa_pkg::KIND_ALLOC, 4'd0, 12'h000);
    send_request(bpa_pkg::KIND_ALLOC, 4'd3, 12'h000);
    send_request(bpa_pkg::KIND_ALLOC, 4'd10, 12'h000);
    send_request(bpa_pkg::KIND_ALLOC, 4'd10, 12'h000);
    send_request(bpa_pkg::KIND_ALLOC, 4'd10, 12'h000);
    wait_drained();
    while (owned_page.size() > 0) begin
      send_request(bpa_pkg::KIND_FREE, owned_ord[0], owned_page[0]);
      void'(owned_page.pop_front());
      void'(owned_ord.pop_front());
    end
    send_request(bpa_pkg::KIND_FREE, 4'd10, 12'h000);
    send_request(bpa_pkg::KIND_FREE, 4'd0, 12'h000);
    wait_drained();
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        3: begin send_idle = 28; recv_stall = 28; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (phase == 4) begin
        // hold the receiver off while requests keep coming
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
          repeat (100) random_request();
        join
      end else begin
        repeat (350) random_request();
      end
      wait_drained();
    end
    $display("Covered %0d good allocates, %0d good frees, %0d empty-pool and %0d bad requests",
             n_alloc_ok, n_free_ok, n_noblk, n_bad);
    $display("across free-flowing, sender-idle, receiver-stall and mixed phases.");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
